>>> src/pce_pkg.sv
`default_nettype none

package pce_pkg;

	// Field widths
	localparam int DUR_W  = 24;
	localparam int SIZE_W = 16;
	localparam int EST_W  = 24;
	localparam int DIFF_W = 25;
	localparam int STEP_W = 12;
	localparam int CFG_W  = 16;
	localparam int IDX_W  = 2;

	// Register reset values
	localparam logic [SIZE_W-1:0] MIN_RST  = 16'd320;
	localparam logic [SIZE_W-1:0] MAX_RST  = 16'd4000;
	localparam logic [STEP_W-1:0] STEP_RST = 12'd80;

	// Bin margins added to the cover bin and the top bin
	localparam int COVER_MARGIN = 2;
	localparam int LECT_MARGIN  = 10;

	typedef enum logic [1:0] {
		REQ_READ  = 2'd0,
		REQ_UP    = 2'd1,
		REQ_DOWN  = 2'd2,
		REQ_ADOPT = 2'd3
	} req_t;

	typedef enum logic [IDX_W-1:0] {
		CFG_MIN_CUSHION  = 2'd0,
		CFG_MAX_CUSHION  = 2'd1,
		CFG_STEP_SIZE    = 2'd2,
		CFG_LECTURE_MODE = 2'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_INIT_WAIT,
		ST_IDLE,
		ST_ISSUE,
		ST_DIV,
		ST_DEC,
		ST_INC_RD,
		ST_INC,
		ST_SCAN,
		ST_MUL,
		ST_EST,
		ST_OUT
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic init;
		logic div_go;
		logic set_start;
		logic accept;
		logic bin_calc;
		logic dec;
		logic inc_rd;
		logic inc;
		logic scan;
		logic est_mul;
		logic est_set;
		logic size_upd;
		logic out_load;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic div_done;
		logic scan_done;
		logic out_free;
		req_t req;
	} sts_t;

endpackage

`default_nettype wire

>>> src/pce_if.sv
`default_nettype none

// Request channel.
interface pce_req_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 req_type;
	logic [pce_pkg::DUR_W-1:0]  read_duration;

	modport source(output valid, output req_type, output read_duration, input ready);
	modport sink(input valid, input req_type, input read_duration, output ready);
endinterface

// Result channel.
interface pce_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [pce_pkg::SIZE_W-1:0]  cur_size;
	logic [pce_pkg::EST_W-1:0]   est_value;
	logic signed [pce_pkg::DIFF_W-1:0] estimate_minus_size;
	logic                        behind_flag;

	modport source(output valid, output cur_size, output est_value,
		output estimate_minus_size, output behind_flag, input ready);
	modport sink(input valid, input cur_size, input est_value,
		input estimate_minus_size, input behind_flag, output ready);
endinterface

`default_nettype wire

>>> src/pce_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module pce_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [pce_pkg::DUR_W-1:0]   dividend,
	input  wire logic [pce_pkg::STEP_W-1:0]  divisor,
	output logic      [pce_pkg::DUR_W-1:0]   quot,
	output logic      [pce_pkg::STEP_W-1:0]  rem,
	output logic                             done
);
	import pce_pkg::*;

	localparam int CNT_W = $clog2(DUR_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DUR_W-1:0]  quot_q;
	logic [STEP_W-1:0] rem_q;
	logic [STEP_W-1:0] div_q;
	logic [STEP_W:0]   trial;
	logic              ge;

	// One trial subtraction per cycle.
	assign trial = {rem_q, quot_q[DUR_W-1]};
	assign ge    = trial >= {1'b0, div_q};

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(DUR_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Partial remainder and quotient.
	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			div_q  <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[DUR_W-2:0], ge};
			rem_q  <= ge ? STEP_W'(trial - {1'b0, div_q}) : trial[STEP_W-1:0];
		end
	end

	assign quot = quot_q;
	assign rem  = rem_q;
	assign done = done_q;

endmodule

`default_nettype wire

>>> src/pce_ctrl.sv
`default_nettype none

// Sequencer of the estimator.
module pce_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire pce_pkg::sts_t sts,
	output pce_pkg::cmd_t      cmd
);
	import pce_pkg::*;

	state_t state_q;
	state_t state_d;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT:      state_d = ST_INIT_WAIT;
			ST_INIT_WAIT: if (sts.div_done) state_d = ST_IDLE;
			ST_IDLE:      if (in_valid) state_d = ST_ISSUE;
			ST_ISSUE: begin
				if (sts.req == REQ_READ || sts.req == REQ_ADOPT) state_d = ST_DIV;
				else state_d = ST_OUT;
			end
			ST_DIV: begin
				if (sts.div_done) state_d = (sts.req == REQ_READ) ? ST_DEC : ST_OUT;
			end
			ST_DEC:    state_d = ST_INC_RD;
			ST_INC_RD: state_d = ST_INC;
			ST_INC:    state_d = ST_SCAN;
			ST_SCAN:   if (sts.scan_done) state_d = ST_MUL;
			ST_MUL:    state_d = ST_EST;
			ST_EST:    state_d = ST_OUT;
			ST_OUT:    if (sts.out_free) state_d = ST_IDLE;
			default:   state_d = ST_INIT;
		endcase
		if (cfg_we) state_d = ST_INIT;
	end

	// Commands.
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_INIT: begin
				cmd.init   = 1'b1;
				cmd.div_go = 1'b1;
			end
			ST_INIT_WAIT: cmd.set_start = sts.div_done;
			ST_IDLE: begin
				in_ready   = !cfg_we;
				cmd.accept = in_valid && !cfg_we;
			end
			ST_ISSUE: begin
				if (sts.req == REQ_READ || sts.req == REQ_ADOPT) cmd.div_go = 1'b1;
				else cmd.size_upd = 1'b1;
			end
			ST_DIV: begin
				cmd.bin_calc = sts.div_done && (sts.req == REQ_READ);
				cmd.size_upd = sts.div_done && (sts.req != REQ_READ);
			end
			ST_DEC:    cmd.dec      = 1'b1;
			ST_INC_RD: cmd.inc_rd   = 1'b1;
			ST_INC:    cmd.inc      = 1'b1;
			ST_SCAN:   cmd.scan     = 1'b1;
			ST_MUL:    cmd.est_mul  = 1'b1;
			ST_EST:    cmd.est_set  = 1'b1;
			ST_OUT:    cmd.out_load = sts.out_free;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_INIT;
		else state_q <= state_d;
	end

endmodule

`default_nettype wire

>>> src/pce_dp.sv
`default_nettype none

// Datapath: registers, window memory, histogram memory, scan and size arithmetic.
module pce_dp #(
	parameter int WINDOW      = 250,
	parameter int BINS        = 51,
	parameter int COVER_COUNT = 225
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [pce_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [pce_pkg::CFG_W-1:0]   cfg_wdata,
	input  wire logic [1:0]                  in_req_type,
	input  wire logic [pce_pkg::DUR_W-1:0]   in_read_duration,
	input  wire pce_pkg::cmd_t               cmd,
	output pce_pkg::sts_t                    sts,
	output logic                             div_go,
	output logic      [pce_pkg::DUR_W-1:0]   div_dividend,
	output logic      [pce_pkg::STEP_W-1:0]  div_divisor,
	input  wire logic [pce_pkg::DUR_W-1:0]   div_quot,
	input  wire logic [pce_pkg::STEP_W-1:0]  div_rem,
	input  wire logic                        div_done,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic      [pce_pkg::SIZE_W-1:0]  out_size,
	output logic      [pce_pkg::EST_W-1:0]   out_estimate,
	output logic signed [pce_pkg::DIFF_W-1:0] out_diff,
	output logic                             out_behind
);
	import pce_pkg::*;

	localparam int BIN_W  = $clog2(BINS);
	localparam int SLOT_W = $clog2(WINDOW);
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int SUM_W  = $clog2(WINDOW + COVER_COUNT + 1);
	localparam int SEL_W  = BIN_W + 2;
	localparam int PROD_W = SEL_W + STEP_W;
	localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(BINS - 1);

	// Configuration registers.
	logic [SIZE_W-1:0] min_q;
	logic [SIZE_W-1:0] max_q;
	logic [STEP_W-1:0] step_q;
	logic              lect_q;
	logic [STEP_W-1:0] step_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q  <= MIN_RST;
			max_q  <= MAX_RST;
			step_q <= STEP_RST;
			lect_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MIN_CUSHION:  min_q  <= cfg_wdata;
				CFG_MAX_CUSHION:  max_q  <= cfg_wdata;
				CFG_STEP_SIZE:    step_q <= cfg_wdata[STEP_W-1:0];
				CFG_LECTURE_MODE: lect_q <= cfg_wdata[0];
				default:          lect_q <= lect_q;
			endcase
		end
	end

	assign step_eff = (step_q == '0) ? STEP_W'(1) : step_q;

	// Latched request.
	req_t             req_q;
	logic [DUR_W-1:0] dur_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= req_t'(in_req_type);
			dur_q <= in_read_duration;
		end
	end

	// Divider operands.
	logic [EST_W-1:0] est_q;
	logic [DUR_W-1:0] min_ext;

	assign min_ext     = DUR_W'(min_q);
	assign div_go      = cmd.div_go;
	assign div_divisor = step_eff;
	always_comb begin
		if (cmd.init) div_dividend = DUR_W'({min_q, 1'b0});
		else if (req_q == REQ_READ) div_dividend = (dur_q > min_ext) ? dur_q : min_ext;
		else div_dividend = est_q;
	end

	// Start bin of a fresh window.
	logic [BIN_W-1:0] start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) start_q <= '0;
		else if (cmd.set_start)
			start_q <= (div_quot > DUR_W'(BINS - 1)) ? LAST_BIN : div_quot[BIN_W-1:0];
	end

	// Bin of the new read, rounded up, with overflow into the last bin.
	logic [DUR_W:0]   ceil_w;
	logic             behind_w;
	logic [BIN_W-1:0] bin_q;
	logic             behind_q;

	assign ceil_w   = {1'b0, div_quot} + (DUR_W + 1)'(div_rem != '0);
	assign behind_w = ceil_w > (DUR_W + 1)'(BINS - 1);

	always_ff @(posedge clk) begin
		if (cmd.bin_calc) begin
			bin_q    <= behind_w ? LAST_BIN : ceil_w[BIN_W-1:0];
			behind_q <= behind_w;
		end
	end

	// Window memory; slots not yet written since init read as the start bin.
	logic [BIN_W-1:0]  win_mem [WINDOW];
	logic [BIN_W-1:0]  win_rdata_q;
	logic [SLOT_W-1:0] slot_q;
	logic              wrapped_q;
	logic [BIN_W-1:0]  old_bin;
	logic [BIN_W-1:0]  old_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) win_rdata_q <= win_mem[slot_q];
		if (cmd.dec) win_mem[slot_q] <= bin_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q    <= '0;
			wrapped_q <= 1'b0;
		end else if (cmd.init) begin
			slot_q    <= '0;
			wrapped_q <= 1'b0;
		end else if (cmd.dec) begin
			if (slot_q == SLOT_W'(WINDOW - 1)) begin
				slot_q    <= '0;
				wrapped_q <= 1'b1;
			end else begin
				slot_q <= slot_q + 1'b1;
			end
		end
	end

	assign old_bin = wrapped_q ? win_rdata_q : start_q;

	always_ff @(posedge clk) begin
		if (cmd.bin_calc) old_q <= old_bin;
	end

	// Histogram memory; entries not written since init read as the reset histogram.
	logic [CNT_W-1:0] cnt_mem [BINS];
	logic [BINS-1:0]  cnt_vld_q;
	logic [CNT_W-1:0] cnt_mem_rd_q;
	logic             vld_rd_q;
	logic             start_rd_q;
	logic [CNT_W-1:0] cnt_rdata;
	logic             cnt_rd_en;
	logic [BIN_W-1:0] cnt_rd_addr;
	logic             cnt_we;
	logic [BIN_W-1:0] cnt_wr_addr;
	logic [CNT_W-1:0] cnt_wdata;
	logic [BIN_W-1:0] scan_rd_q;
	logic             issued_all_q;
	logic             scan_issue;

	assign scan_issue  = cmd.scan && !issued_all_q;
	assign cnt_rd_en   = cmd.bin_calc || cmd.inc_rd || scan_issue;
	assign cnt_rd_addr = cmd.bin_calc ? old_bin : (cmd.inc_rd ? bin_q : scan_rd_q);
	assign cnt_we      = cmd.dec || cmd.inc;
	assign cnt_wr_addr = cmd.dec ? old_q : bin_q;
	assign cnt_rdata   = vld_rd_q ? cnt_mem_rd_q : (start_rd_q ? CNT_W'(WINDOW) : '0);
	always_comb begin
		if (cmd.dec) cnt_wdata = (cnt_rdata != '0) ? cnt_rdata - 1'b1 : cnt_rdata;
		else cnt_wdata = cnt_rdata + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cnt_rd_en) begin
			cnt_mem_rd_q <= cnt_mem[cnt_rd_addr];
			vld_rd_q     <= cnt_vld_q[cnt_rd_addr];
			start_rd_q   <= (cnt_rd_addr == start_q);
		end
		if (cnt_we) cnt_mem[cnt_wr_addr] <= cnt_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_vld_q <= '0;
		else if (cmd.init) cnt_vld_q <= '0;
		else if (cnt_we) cnt_vld_q[cnt_wr_addr] <= 1'b1;
	end

	// Histogram scan: one bin read per cycle, accumulated in the cycle after its read.
	logic             scan_v_s1;
	logic [BIN_W-1:0] scan_k_s1;
	logic [SUM_W-1:0] acc_q;
	logic [SUM_W-1:0] cov_cnt_q;
	logic [BIN_W-1:0] cov_idx_q;
	logic [BIN_W:0]   top_q;
	logic             stop_q;
	logic [SUM_W-1:0] acc_n;

	assign acc_n = acc_q + SUM_W'(cnt_rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_rd_q    <= '0;
			issued_all_q <= 1'b0;
			scan_v_s1    <= 1'b0;
			stop_q       <= 1'b0;
			acc_q        <= '0;
			cov_cnt_q    <= '0;
			cov_idx_q    <= '0;
			top_q        <= '0;
		end else if (cmd.inc) begin
			scan_rd_q    <= '0;
			issued_all_q <= 1'b0;
			scan_v_s1    <= 1'b0;
			stop_q       <= 1'b0;
			acc_q        <= '0;
			cov_cnt_q    <= '0;
			cov_idx_q    <= '0;
			top_q        <= '0;
		end else begin
			scan_v_s1 <= scan_issue;
			if (scan_issue) begin
				if (scan_rd_q == LAST_BIN) issued_all_q <= 1'b1;
				else scan_rd_q <= scan_rd_q + 1'b1;
			end
			if (scan_v_s1 && !stop_q) begin
				acc_q <= acc_n;
				if (cov_cnt_q < SUM_W'(COVER_COUNT)) begin
					cov_cnt_q <= cov_cnt_q + SUM_W'(cnt_rdata);
					cov_idx_q <= scan_k_s1;
				end
				top_q  <= (BIN_W + 1)'(scan_k_s1) + 1'b1;
				stop_q <= (acc_n >= SUM_W'(WINDOW)) || (scan_k_s1 == LAST_BIN);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_issue) scan_k_s1 <= scan_rd_q;
	end

	// Estimate: bounded bin count times the step, raised to the minimum.
	logic [SEL_W-1:0]  lower;
	logic [SEL_W-1:0]  upper;
	logic [SEL_W-1:0]  sel;
	logic [PROD_W-1:0] prod_q;

	assign lower = SEL_W'(cov_idx_q) + (lect_q ? SEL_W'(LECT_MARGIN) : SEL_W'(COVER_MARGIN));
	assign upper = SEL_W'(top_q) + (lect_q ? SEL_W'(LECT_MARGIN) : SEL_W'(0));
	assign sel   = (lower < upper) ? lower : upper;

	always_ff @(posedge clk) begin
		if (cmd.est_mul) prod_q <= sel * step_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) est_q <= EST_W'({MIN_RST, 1'b0});
		else if (cmd.init) est_q <= EST_W'({min_q, 1'b0});
		else if (cmd.est_set)
			est_q <= (EST_W'(prod_q) < EST_W'(min_q)) ? EST_W'(min_q) : EST_W'(prod_q);
	end

	// Cushion size updates, clamped to the configured range.
	logic [SIZE_W-1:0] size_q;
	logic [DIFF_W-1:0] size_raw;
	logic [DIFF_W-1:0] size_lo;

	always_comb begin
		case (req_q)
			REQ_UP:   size_raw = DIFF_W'(size_q) + DIFF_W'(step_eff);
			REQ_DOWN: size_raw = (size_q > SIZE_W'(step_eff)) ?
				DIFF_W'(size_q - SIZE_W'(step_eff)) : '0;
			REQ_ADOPT: size_raw = DIFF_W'(est_q) + DIFF_W'(step_eff) - DIFF_W'(div_rem);
			default:  size_raw = DIFF_W'(size_q);
		endcase
		size_lo = (size_raw < DIFF_W'(min_q)) ? DIFF_W'(min_q) : size_raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) size_q <= '0;
		else if (cmd.size_upd)
			size_q <= (size_lo > DIFF_W'(max_q)) ? max_q : size_lo[SIZE_W-1:0];
	end

	// Output register.
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.out_load) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_size     <= size_q;
			out_estimate <= est_q;
			out_diff     <= DIFF_W'(est_q) - DIFF_W'(size_q);
			out_behind   <= (req_q == REQ_READ) && behind_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign sts.div_done  = div_done;
	assign sts.scan_done = stop_q;
	assign sts.out_free  = !out_valid_q || out_ready;
	assign sts.req       = req_q;

	// The histogram port never reads and writes in the same cycle.
	a_cnt_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(cnt_rd_en && cnt_we))
		else $error("histogram read and write collide");

	// The running total of a scan never passes the window length.
	a_acc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q <= SUM_W'(WINDOW))
		else $error("histogram scan total exceeds window");

	// A new estimate is never below the minimum in force when it was set.
	a_est_min: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.est_set |=> est_q >= EST_W'($past(min_q)))
		else $error("estimate below minimum cushion");

	// A loaded result is presented on the next cycle.
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("loaded result not presented");

	// The write slot stays inside the window.
	a_slot: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= SLOT_W'(WINDOW - 1))
		else $error("write slot out of range");

endmodule

`default_nettype wire

>>> src/playout_cushion_estimator_unit.sv
`default_nettype none

// Channel  Modport  Payload                                               Request moves
// req      sink     req_type, read_duration                               one request
// rsp      source   cur_size, est_value, estimate_minus_size,             one result
//                   behind_flag
// cfg      plain    cfg_we, cfg_index, cfg_wdata                          one register write
//
// A recorded read runs the 24-step divider, then scans the single-port histogram memory
// up to the bin where the running count reaches the window length, or to the last bin.
// Adopt runs the divider as well; step requests (up, down) do not use it.
// After reset, and after a register write, the block recomputes the start bin on the
// divider with req.ready low.
// One request is in flight at a time; a finished result waits in the output register
// while the next request is accepted.
module playout_cushion_estimator_unit #(
	parameter int WINDOW      = 250,
	parameter int BINS        = 51,
	parameter int COVER_COUNT = 225
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	pce_req_if.sink                          req,
	pce_rsp_if.source                        rsp,
	input  wire logic                        cfg_we,
	input  wire logic [pce_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [pce_pkg::CFG_W-1:0]   cfg_wdata
);
	import pce_pkg::*;

	cmd_t              cmd;
	sts_t              sts;
	logic              div_go;
	logic [DUR_W-1:0]  div_dividend;
	logic [STEP_W-1:0] div_divisor;
	logic [DUR_W-1:0]  div_quot;
	logic [STEP_W-1:0] div_rem;
	logic              div_done;

	pce_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pce_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quot     (div_quot),
		.rem      (div_rem),
		.done     (div_done)
	);

	pce_dp #(
		.WINDOW      (WINDOW),
		.BINS        (BINS),
		.COVER_COUNT (COVER_COUNT)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.in_req_type      (req.req_type),
		.in_read_duration (req.read_duration),
		.cmd              (cmd),
		.sts              (sts),
		.div_go           (div_go),
		.div_dividend     (div_dividend),
		.div_divisor      (div_divisor),
		.div_quot         (div_quot),
		.div_rem          (div_rem),
		.div_done         (div_done),
		.out_valid        (rsp.valid),
		.out_ready        (rsp.ready),
		.out_size         (rsp.cur_size),
		.out_estimate     (rsp.est_value),
		.out_diff         (rsp.estimate_minus_size),
		.out_behind       (rsp.behind_flag)
	);

endmodule

`default_nettype wire

>>> test/tb_playout_cushion_estimator_unit.sv
`timescale 1ns / 100ps

module tb_playout_cushion_estimator_unit;
	import pce_pkg::*;

	localparam int WIN_LEN     = 250;
	localparam int BIN_NUM     = 51;
	localparam int COVER_TOTAL = 225;

	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic [EST_W-1:0]  est;
		logic [DIFF_W-1:0] diff;
		logic              behind;
	} cushion_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	pce_req_if req ();
	pce_rsp_if rsp ();

	playout_cushion_estimator_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// Shadow copy of the estimator state and its registers.
	logic [5:0] win_bin [WIN_LEN];
	int unsigned bin_cnt [BIN_NUM];
	int unsigned wr_slot;
	int unsigned est_q;
	int unsigned size_q;
	int unsigned min_q;
	int unsigned max_q;
	int unsigned step_q;
	int unsigned lect_q;

	cushion_result_t pending_results [$];
	int mismatches;
	bit idle_on;
	bit hold_go;
	int rsp_stall;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("playout_cushion_estimator_unit test failed");
		$finish;
	end

	function automatic int unsigned step_eff();
		return (step_q == 0) ? 1 : step_q;
	endfunction

	function automatic void window_reset();
		int unsigned start;
		start = (2 * min_q) / step_eff();
		if (start > BIN_NUM - 1) start = BIN_NUM - 1;
		for (int i = 0; i < WIN_LEN; i++) win_bin[i] = start[5:0];
		for (int i = 0; i < BIN_NUM; i++) bin_cnt[i] = 0;
		bin_cnt[start] = WIN_LEN;
		wr_slot = 0;
		est_q = (2 * min_q) & 32'hFFFFFF;
	endfunction

	function automatic int unsigned size_clamp(int unsigned s);
		if (s < min_q) s = min_q;
		if (s > max_q) s = max_q;
		return s & 32'hFFFF;
	endfunction

	// Slide the window, update the histogram and rescan it for a new estimate.
	function automatic bit read_update(int unsigned dur);
		int unsigned stp, m, bin, old, idx, total, cov_idx, cov_cnt, lo, hi, e;
		bit behind;
		stp = step_eff();
		m = (dur > min_q) ? dur : min_q;
		bin = (m + stp - 1) / stp;
		behind = 1'b0;
		old = 32'(win_bin[wr_slot]);
		if (old > BIN_NUM - 1) old = BIN_NUM - 1;
		if (bin_cnt[old] > 0) bin_cnt[old]--;
		if (bin > BIN_NUM - 1) begin
			bin = BIN_NUM - 1;
			behind = 1'b1;
		end
		win_bin[wr_slot] = bin[5:0];
		bin_cnt[bin]++;
		wr_slot = (wr_slot + 1 >= WIN_LEN) ? 0 : wr_slot + 1;
		idx = 0; total = 0; cov_idx = 0; cov_cnt = 0;
		while (idx < BIN_NUM && total < WIN_LEN) begin
			if (cov_cnt < COVER_TOTAL) begin
				cov_cnt += bin_cnt[idx];
				cov_idx = idx;
			end
			total += bin_cnt[idx];
			idx++;
		end
		if (lect_q[0]) begin
			lo = cov_idx + LECT_MARGIN;
			hi = idx + LECT_MARGIN;
		end else begin
			lo = cov_idx + COVER_MARGIN;
			hi = idx;
		end
		e = ((lo < hi) ? lo : hi) * stp;
		if (e < min_q) e = min_q;
		est_q = e & 32'hFFFFFF;
		return behind;
	endfunction

	function automatic cushion_result_t predict_cushion(req_t rt, logic [DUR_W-1:0] dur);
		cushion_result_t r;
		int unsigned stp;
		bit behind;
		stp = step_eff();
		behind = 1'b0;
		case (rt)
			REQ_READ: behind = read_update(32'(dur));
			REQ_UP: size_q = size_clamp(size_q + stp);
			REQ_DOWN: size_q = size_clamp((size_q > stp) ? size_q - stp : 0);
			default: size_q = size_clamp(est_q + stp - (est_q % stp));
		endcase
		r.size = size_q[SIZE_W-1:0];
		r.est = est_q[EST_W-1:0];
		r.diff = est_q[DIFF_W-1:0] - {9'd0, size_q[SIZE_W-1:0]};
		r.behind = behind;
		return r;
	endfunction

	// Result checker against the oldest expectation.
	always @(posedge clk) begin
		cushion_result_t want, got;
		if (arst_n && rsp.valid && rsp.ready) begin
			got = {rsp.cur_size, rsp.est_value, rsp.estimate_minus_size,
				rsp.behind_flag};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected result %h", got);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: size %0d/%0d est %0d/%0d diff %h/%h behind %b/%b",
							got.size, want.size, got.est, want.est, got.diff, want.diff,
							got.behind, want.behind);
				end
			end
		end
	end

	// Long receiver hold-off, counted here while the sender keeps going.
	always begin
		wait (hold_go);
		repeat (300) @(posedge clk);
		hold_go = 1'b0;
	end

	// Result ready with random stall bursts.
	always @(negedge clk) begin
		if (hold_go) begin
			rsp.ready <= 1'b0;
		end else if (idle_on && rsp_stall > 0) begin
			rsp.ready <= 1'b0;
			rsp_stall--;
		end else if (idle_on && $urandom_range(0, 6) == 0) begin
			rsp.ready <= 1'b0;
			rsp_stall = $urandom_range(1, 12) - 1;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	task automatic send_request(req_t rt, logic [DUR_W-1:0] dur);
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 12);
			@(negedge clk);
			req.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req.valid <= 1'b1;
		req.req_type <= rt;
		req.read_duration <= dur;
		do @(posedge clk); while (!req.ready);
		pending_results.push_back(predict_cushion(rt, dur));
	endtask

	task automatic drain();
		@(negedge clk);
		req.valid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_register(cfg_idx_t idx, logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_MIN_CUSHION: min_q = 32'(data);
			CFG_MAX_CUSHION: max_q = 32'(data);
			CFG_STEP_SIZE: step_q = 32'(data[STEP_W-1:0]);
			default: lect_q = 32'(data[0]);
		endcase
		window_reset();
		repeat (40) @(posedge clk);
	endtask

	task automatic apply_setting(logic [15:0] mn, logic [15:0] mx, logic [15:0] st, bit lm);
		write_register(CFG_MIN_CUSHION, mn);
		write_register(CFG_MAX_CUSHION, mx);
		write_register(CFG_STEP_SIZE, st);
		write_register(CFG_LECTURE_MODE, {15'd0, lm});
	endtask

	// Durations that land mostly inside the histogram, sometimes anywhere.
	function automatic logic [DUR_W-1:0] pick_duration();
		int unsigned hi;
		hi = step_eff() * 55;
		if (hi > 24'hFFFFFF) hi = 24'hFFFFFF;
		case ($urandom_range(0, 9))
			0: return DUR_W'($urandom());
			1: return DUR_W'($urandom_range(0, min_q + 2));
			default: return DUR_W'($urandom_range(0, hi));
		endcase
	endfunction

	function automatic req_t pick_request();
		case ($urandom_range(0, 9))
			0, 1: return REQ_UP;
			2, 3: return REQ_DOWN;
			4: return REQ_ADOPT;
			default: return REQ_READ;
		endcase
	endfunction

	task automatic test_directed();
		send_request(REQ_READ, 24'd0);
		send_request(REQ_DOWN, 24'hFFFFFF);
		send_request(REQ_READ, 24'hFFFFFF);
		send_request(REQ_READ, 24'd320);
		send_request(REQ_READ, 24'd321);
		send_request(REQ_READ, 24'd4000);
		send_request(REQ_READ, 24'd4001);
		send_request(REQ_ADOPT, 24'd0);
		repeat (3) send_request(REQ_UP, 24'd0);
		repeat (5) send_request(REQ_DOWN, 24'd0);
		repeat (60) send_request(REQ_UP, 24'hAAAAAA);
		send_request(REQ_ADOPT, 24'h555555);
		repeat (6) send_request(REQ_READ, 24'd80);
		send_request(REQ_ADOPT, 24'd0);
		drain();
	endtask

	task automatic test_random(int n);
		repeat (n) send_request(pick_request(), pick_duration());
		drain();
	endtask

	task automatic test_settings();
		apply_setting(16'd1, 16'd65535, 16'd1, 1'b0);
		test_random(150);
		apply_setting(16'd0, 16'd65535, 16'd4095, 1'b1);
		test_random(150);
		apply_setting(16'd65535, 16'd1, 16'd7, 1'b0);
		test_random(150);
		apply_setting(16'd100, 16'd3000, 16'hF000, 1'b1);
		test_random(150);
		apply_setting(16'd320, 16'd4000, 16'd80, 1'b1);
		test_random(150);
		apply_setting(16'd4000, 16'd65535, 16'hFFFF, 1'b0);
		test_random(150);
		apply_setting(16'd50, 16'd60000, 16'd37, 1'b0);
		test_random(150);
	endtask

	task automatic test_backpressure();
		hold_go = 1'b1;
		repeat (40) send_request(pick_request(), pick_duration());
		drain();
	endtask

	task automatic test_no_idle();
		idle_on = 1'b0;
		apply_setting(16'd320, 16'd4000, 16'd80, 1'b0);
		test_random(200);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		req.valid = 1'b0;
		req.req_type = REQ_READ;
		req.read_duration = '0;
		rsp.ready = 1'b0;
		mismatches = 0;
		idle_on = 1'b1;
		hold_go = 1'b0;
		rsp_stall = 0;
		min_q = 32'(MIN_RST);
		max_q = 32'(MAX_RST);
		step_q = 32'(STEP_RST);
		lect_q = 0;
		size_q = 0;
		window_reset();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (40) @(posedge clk);

		test_directed();
		test_random(100);
		test_backpressure();
		test_settings();
		test_no_idle();

		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("playout_cushion_estimator_unit test passed");
		end else begin
			$display("playout_cushion_estimator_unit test failed");
		end
		$finish;
	end

endmodule

>>> playout_cushion_estimator_unit.f
src/pce_pkg.sv
src/pce_if.sv
src/pce_div.sv
src/pce_ctrl.sv
src/pce_dp.sv
src/playout_cushion_estimator_unit.sv
test/tb_playout_cushion_estimator_unit.sv
